FILE: sv/lodd_pkg.sv
// lodd_pkg: sizes, codes and shared types for the lock-order deadlock detector
// used by lodd_prune and lock_order_deadlock_detector; depends on nothing else
`timescale 1ns / 1ps

package lodd_pkg;

  // block sizes
  localparam int MUTEXES    = 8;
  localparam int THREADS    = 4;
  localparam int HOLD_DEPTH = 8;

  // beat field widths
  localparam int CMD_W    = 1;
  localparam int THREAD_W = 2;
  localparam int MUTEX_W  = 3;
  localparam int STATUS_W = 2;
  localparam int EDGES_W  = 7;

  // derived index and count widths
  localparam int THR_IDX_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int MUT_IDX_W = $clog2(MUTEXES);
  localparam int DEPTH_W   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CNT_W     = $clog2(HOLD_DEPTH + 1);
  localparam int ADDR_W    = (THREADS * HOLD_DEPTH > 1) ? $clog2(THREADS * HOLD_DEPTH) : 1;
  localparam int STACK_N   = THREADS * HOLD_DEPTH;
  localparam int LEFT_W    = $clog2(MUTEXES * MUTEXES + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOCK   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEADLOCK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED   = 2'd3;

  // lock-order matrix: row r, bit c means edge r -> c
  typedef logic [MUTEXES-1:0] row_t;
  typedef row_t [MUTEXES-1:0] matrix_t;

  // result of one cycle check
  typedef struct packed {
    logic              done;
    logic [LEFT_W-1:0] left;
  } prune_rsp_t;

  // flat held-stack address of entry idx of thread thr
  function automatic logic [ADDR_W-1:0] stack_addr(input logic [THR_IDX_W-1:0] thr,
                                                   input logic [DEPTH_W-1:0] idx);
    stack_addr = ADDR_W'(ADDR_W'(thr) * ADDR_W'(HOLD_DEPTH) + ADDR_W'(idx));
  endfunction

endpackage

FILE: sv/lodd_prune.sv
// lodd_prune: cycle check on a copy of the lock-order matrix, one vertex a cycle
// strips sources and sinks until a round changes nothing, then counts edges left
// depends on lodd_pkg
`timescale 1ns / 1ps

module lodd_prune import lodd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  matrix_t    edges_i,
  output prune_rsp_t rsp_o
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_SCAN  = 2'd1;
  localparam logic [1:0] P_COUNT = 2'd2;

  logic [1:0]           state_q, state_d;
  matrix_t              g_q, g_d;
  logic [MUT_IDX_W-1:0] v_q, v_d;
  logic                 changed_q, changed_d;
  logic [LEFT_W-1:0]    sum_q, sum_d;
  logic                 done_q, done_d;
  logic                 has_out, has_in, remove, last_v;
  logic [LEFT_W-1:0]    row_pop;

  // vertex test on the current copy
  always_comb begin
    has_in = 1'b0;
    for (int r = 0; r < MUTEXES; r++) begin
      has_in = has_in | g_q[r][v_q];
    end
    has_out = |g_q[v_q];
    remove  = has_out ^ has_in;
    last_v  = (v_q == MUT_IDX_W'(MUTEXES - 1));
  end

  // edges in the current row
  always_comb begin
    row_pop = '0;
    for (int c = 0; c < MUTEXES; c++) begin
      row_pop = row_pop + LEFT_W'(g_q[v_q][c]);
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    g_d       = g_q;
    v_d       = v_q;
    changed_d = changed_q;
    sum_d     = sum_q;
    done_d    = 1'b0;
    unique case (state_q)
      P_IDLE: begin
        if (start_i) begin
          g_d       = edges_i;
          v_d       = '0;
          changed_d = 1'b0;
          state_d   = P_SCAN;
        end
      end
      P_SCAN: begin
        if (remove) begin
          g_d[v_q] = '0;
          for (int r = 0; r < MUTEXES; r++) begin
            g_d[r][v_q] = 1'b0;
          end
        end
        if (last_v) begin
          v_d       = '0;
          changed_d = 1'b0;
          if (!(changed_q || remove)) begin
            sum_d   = '0;
            state_d = P_COUNT;
          end
        end else begin
          v_d       = v_q + 1'b1;
          changed_d = changed_q | remove;
        end
      end
      P_COUNT: begin
        sum_d = sum_q + row_pop;
        if (last_v) begin
          done_d  = 1'b1;
          state_d = P_IDLE;
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // working copy and counters
  always_ff @(posedge clk_i) begin
    g_q       <= g_d;
    v_q       <= v_d;
    changed_q <= changed_d;
    sum_q     <= sum_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.left = sum_q;

  // a new check only starts while idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == P_IDLE)
    else $error("cycle check started while busy");

  // done follows the last counted row
  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == P_COUNT)
    else $error("done without a count pass");

  // the count never exceeds the matrix size
  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> int'(sum_q) <= MUTEXES * MUTEXES)
    else $error("edge count out of range");

endmodule

FILE: sv/lock_order_deadlock_detector.sv
// lock_order_deadlock_detector: lock/unlock events in, one status beat out per event.
// Halted or ignored events go straight to the result; an unlock walks the held stack;
// a lock waits on the one-vertex-a-cycle cycle check.
// One event at a time; the next is taken once this one's result is registered.
// Reset: no order edges, empty held stacks, no deadlock; the held-stack memory is not cleared.
// depends on lodd_pkg and lodd_prune
`timescale 1ns / 1ps

module lock_order_deadlock_detector import lodd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [1:0] thread_id, [4:2] mutex_id, [7:5] zero
  input  logic [0:0] s_axis_tuser_i,   // [0] command
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [1:0] status, [8:2] cycle_edges, [15:9] zero
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LK_RD   = 3'd1;
  localparam logic [2:0] S_LK_UPD  = 3'd2;
  localparam logic [2:0] S_LK_CHK  = 3'd3;
  localparam logic [2:0] S_LK_WAIT = 3'd4;
  localparam logic [2:0] S_UL_RD   = 3'd5;
  localparam logic [2:0] S_UL_CMP  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [THREAD_W-1:0] tid_q;
  logic [MUTEX_W-1:0]  mid_q;
  matrix_t             order_edges_q, order_edges_d;
  logic [CNT_W-1:0]    held_count_q [THREADS];
  logic [CNT_W-1:0]    held_count_d [THREADS];
  logic                deadlock_seen_q, deadlock_seen_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    keep_q, keep_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [EDGES_W-1:0]  res_edges_q, res_edges_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [EDGES_W-1:0]  out_edges_q;
  logic                in_beat, out_load;
  logic [THREAD_W-1:0] in_tid;
  logic [MUTEX_W-1:0]  in_mid;
  logic [THR_IDX_W-1:0] thr;
  logic [MUT_IDX_W-1:0] mut;
  logic [CNT_W-1:0]    cur_count;
  logic                prune_start;
  prune_rsp_t          prune_rsp;

  // held-stack memory
  logic [MUTEX_W-1:0]  held_stack [STACK_N];
  logic [ADDR_W-1:0]   mem_raddr, mem_waddr;
  logic                mem_we;
  logic [MUTEX_W-1:0]  mem_wdata, mem_rdata_q;

  // beat fields and current thread view
  assign in_tid    = s_axis_tdata_i[THREAD_W-1:0];
  assign in_mid    = s_axis_tdata_i[THREAD_W +: MUTEX_W];
  assign in_beat   = s_axis_tvalid_i & s_axis_tready_o;
  assign thr       = THR_IDX_W'(tid_q);
  assign mut       = MUT_IDX_W'(mid_q);
  assign cur_count = held_count_q[thr];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_load        = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  // memory port selection
  always_comb begin
    mem_raddr = stack_addr(thr, DEPTH_W'(idx_q));
    mem_we    = 1'b0;
    mem_waddr = stack_addr(thr, DEPTH_W'(cur_count));
    mem_wdata = mid_q;
    unique case (state_q)
      S_LK_RD: mem_raddr = stack_addr(thr, DEPTH_W'(cur_count - CNT_W'(1)));
      S_LK_UPD: mem_we = (cur_count < CNT_W'(HOLD_DEPTH));
      S_UL_CMP: begin
        mem_we    = (mem_rdata_q != mid_q);
        mem_waddr = stack_addr(thr, DEPTH_W'(keep_q));
        mem_wdata = mem_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      held_stack[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= held_stack[mem_raddr];
  end

  // event sequencer
  always_comb begin
    state_d         = state_q;
    order_edges_d   = order_edges_q;
    held_count_d    = held_count_q;
    deadlock_seen_d = deadlock_seen_q;
    idx_d           = idx_q;
    keep_d          = keep_q;
    res_status_d    = res_status_q;
    res_edges_d     = res_edges_q;
    prune_start     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          res_status_d = ST_OK;
          res_edges_d  = '0;
          idx_d        = '0;
          keep_d       = '0;
          priority if (deadlock_seen_q) begin
            res_status_d = ST_HALTED;
            state_d      = S_FIN;
          end else if (int'(in_tid) >= THREADS || int'(in_mid) >= MUTEXES) begin
            state_d = S_FIN;
          end else if (s_axis_tuser_i == CMD_LOCK) begin
            state_d = S_LK_RD;
          end else begin
            state_d = S_UL_RD;
          end
        end
      end
      S_LK_RD: state_d = S_LK_UPD;
      S_LK_UPD: begin
        // edge from the top of the stack, then push if there is room
        if (cur_count != '0 && int'(mem_rdata_q) < MUTEXES) begin
          order_edges_d[MUT_IDX_W'(mem_rdata_q)][mut] = 1'b1;
        end
        if (cur_count < CNT_W'(HOLD_DEPTH)) begin
          held_count_d[thr] = cur_count + 1'b1;
        end else begin
          res_status_d = ST_OVERFLOW;
        end
        state_d = S_LK_CHK;
      end
      S_LK_CHK: begin
        prune_start = 1'b1;
        state_d     = S_LK_WAIT;
      end
      S_LK_WAIT: begin
        if (prune_rsp.done) begin
          if (prune_rsp.left != '0) begin
            deadlock_seen_d = 1'b1;
            res_status_d    = ST_DEADLOCK;
            res_edges_d     = EDGES_W'(prune_rsp.left);
          end
          state_d = S_FIN;
        end
      end
      S_UL_RD: begin
        if (idx_q == cur_count) begin
          held_count_d[thr] = keep_q;
          state_d           = S_FIN;
        end else begin
          state_d = S_UL_CMP;
        end
      end
      S_UL_CMP: begin
        // keep entries that differ from the released mutex, in order
        if (mem_rdata_q != mid_q) begin
          keep_d = keep_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_UL_RD;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register hand-off
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      order_edges_q   <= '0;
      deadlock_seen_q <= 1'b0;
      out_valid_q     <= 1'b0;
      for (int t = 0; t < THREADS; t++) begin
        held_count_q[t] <= '0;
      end
    end else begin
      state_q         <= state_d;
      order_edges_q   <= order_edges_d;
      deadlock_seen_q <= deadlock_seen_d;
      out_valid_q     <= out_valid_d;
      held_count_q    <= held_count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cmd_q <= s_axis_tuser_i;
      tid_q <= in_tid;
      mid_q <= in_mid;
    end
    idx_q        <= idx_d;
    keep_q       <= keep_d;
    res_status_q <= res_status_d;
    res_edges_q  <= res_edges_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_edges_q  <= res_edges_q;
    end
  end

  // cycle check unit
  lodd_prune u_prune (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prune_start),
    .edges_i (order_edges_q),
    .rsp_o   (prune_rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - STATUS_W - EDGES_W){1'b0}}, out_edges_q, out_status_q};

  // deadlock is sticky
  a_deadlock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deadlock_seen_q |=> deadlock_seen_q)
    else $error("deadlock flag cleared");

  // no cycle check once halted, and only for a lock
  a_start_lock_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prune_start |-> !deadlock_seen_q && cmd_q == CMD_LOCK)
    else $error("cycle check on a halted block or an unlock");

  // check results arrive only while waiting for them
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prune_rsp.done |-> state_q == S_LK_WAIT)
    else $error("unexpected cycle check result");

  // edge count is nonzero exactly on a deadlock result
  a_edges_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_status_q == ST_DEADLOCK) == (out_edges_q != '0)))
    else $error("edge count disagrees with status");

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for lock_order_deadlock_detector, driving lock/unlock beats
// against an in-bench lock-order graph and checking every status beat; needs lodd_pkg
`timescale 1ns / 1ps

module tb;
  import lodd_pkg::*;

  // one lock or unlock event
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [THREAD_W-1:0] thr;
    logic [MUTEX_W-1:0]  mtx;
  } lock_event_t;

  // one status beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EDGES_W-1:0]  edges;
  } verdict_t;

  // detector state: order matrix, held stacks, depths, sticky deadlock
  typedef struct packed {
    matrix_t                                         order;
    logic [THREADS-1:0][HOLD_DEPTH-1:0][MUTEX_W-1:0] held;
    logic [THREADS-1:0][CNT_W-1:0]                   depth;
    logic                                            halted;
  } lock_graph_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  lock_event_t pending[$];
  verdict_t    verdict_q[$];
  lock_graph_t graph_plan;
  lock_graph_t graph_now;
  int          src_gap = 0;
  int          sink_gap = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          results_seen = 0;
  int          mismatches = 0;
  logic        calm;

  lock_order_deadlock_detector uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // no idling once the stimulus is nearly used up
  assign calm = (pending.size() < 60);

  // prune vertices that are only sources or only sinks, count the edges left
  function automatic int residual_edges(input matrix_t order);
    matrix_t g;
    logic    changed;
    logic    has_out;
    logic    has_in;
    int      left;
    g = order;
    left = 0;
    do begin
      changed = 1'b0;
      for (int v = 0; v < MUTEXES; v++) begin
        has_out = |g[v];
        has_in = 1'b0;
        for (int r = 0; r < MUTEXES; r++) has_in |= g[r][v];
        if (has_out != has_in) begin
          g[v] = '0;
          for (int r = 0; r < MUTEXES; r++) g[r][v] = 1'b0;
          changed = 1'b1;
        end
      end
    end while (changed);
    for (int r = 0; r < MUTEXES; r++)
      for (int c = 0; c < MUTEXES; c++) left += int'(g[r][c]);
    return left;
  endfunction

  // next detector state and the status beat that one event yields
  function automatic lock_graph_t detector_step(input lock_graph_t s, input lock_event_t ev,
                                                output verdict_t v);
    lock_graph_t        nx;
    int                 n;
    int                 k;
    logic [MUTEX_W-1:0] top;
    nx = s;
    v = '0;
    if (s.halted) begin
      v.status = ST_HALTED;
      return nx;
    end
    if (int'(ev.thr) >= THREADS || int'(ev.mtx) >= MUTEXES) return nx;
    n = int'(s.depth[ev.thr]);
    if (n > HOLD_DEPTH) n = HOLD_DEPTH;
    if (ev.cmd == CMD_LOCK) begin
      // edge from the most recent held mutex, then push or drop
      if (n > 0) begin
        top = s.held[ev.thr][n-1];
        nx.order[top][ev.mtx] = 1'b1;
      end
      if (n < HOLD_DEPTH) begin
        nx.held[ev.thr][n] = ev.mtx;
        nx.depth[ev.thr] = CNT_W'(n + 1);
      end else begin
        v.status = ST_OVERFLOW;
      end
      k = residual_edges(nx.order);
      if (k > 0) begin
        nx.halted = 1'b1;
        v.status = ST_DEADLOCK;
        v.edges = EDGES_W'(k);
      end
    end else begin
      // drop every copy of the mutex, keep the order of the rest
      k = 0;
      for (int i = 0; i < n; i++) begin
        if (s.held[ev.thr][i] != ev.mtx) begin
          nx.held[ev.thr][k] = s.held[ev.thr][i];
          k++;
        end
      end
      nx.depth[ev.thr] = CNT_W'(k);
    end
    return nx;
  endfunction

  // would this lock close a cycle in the planned graph
  function automatic logic lock_closes_cycle(input lock_graph_t s, input logic [THREAD_W-1:0] thr,
                                             input logic [MUTEX_W-1:0] mtx);
    lock_event_t ev;
    verdict_t    v;
    ev.cmd = CMD_LOCK;
    ev.thr = thr;
    ev.mtx = mtx;
    void'(detector_step(s, ev, v));
    return v.status == ST_DEADLOCK;
  endfunction

  // mutexes in an order that agrees with every edge of an acyclic graph
  function automatic logic [MUTEXES-1:0][MUTEX_W-1:0] topo_order(input matrix_t g);
    logic [MUTEXES-1:0][MUTEX_W-1:0] seq;
    row_t placed;
    logic blocked;
    int   k;
    seq = '0;
    placed = '0;
    k = 0;
    for (int pass = 0; pass < MUTEXES; pass++) begin
      for (int v = 0; v < MUTEXES; v++) begin
        if (!placed[v]) begin
          blocked = 1'b0;
          for (int r = 0; r < MUTEXES; r++)
            if (!placed[r] && r != v && g[r][v]) blocked = 1'b1;
          if (!blocked && k < MUTEXES) begin
            seq[k] = MUTEX_W'(v);
            placed[v] = 1'b1;
            k++;
          end
        end
      end
    end
    return seq;
  endfunction

  // append an event and track it in the planning graph
  task automatic queue_event(input logic [CMD_W-1:0] cmd, input logic [THREAD_W-1:0] thr,
                             input logic [MUTEX_W-1:0] mtx);
    lock_event_t ev;
    verdict_t    ignored;
    ev.cmd = cmd;
    ev.thr = thr;
    ev.mtx = mtx;
    pending = {pending, ev};
    graph_plan = detector_step(graph_plan, ev, ignored);
  endtask

  // source side: offer queued events, predict each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    lock_event_t ev;
    verdict_t    v;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
      graph_now = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        ev.cmd = s_tuser[0];
        ev.thr = s_tdata[1:0];
        ev.mtx = s_tdata[4:2];
        graph_now = detector_step(graph_now, ev, v);
        verdict_q = {verdict_q, v};
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          s_tvalid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
          s_tvalid <= 1'b0;
          src_gap <= $urandom_range(0, 3);
        end else if (pending.size() != 0) begin
          ev = pending.pop_front();
          s_tdata <= {3'b000, ev.mtx, ev.thr};
          s_tuser <= ev.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the source keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == 120) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // sink side: check each status beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status beat: status %0d edges %0d", m_tdata[1:0],
                     m_tdata[8:2]);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[1:0] != want.status || m_tdata[8:2] != want.edges) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: want status %0d edges %0d, got status %0d edges %0d",
                       results_seen, want.status, want.edges, m_tdata[1:0], m_tdata[8:2]);
          end
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        m_tready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        sink_gap <= $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [THREAD_W-1:0]             thr;
    logic [MUTEX_W-1:0]              mtx;
    logic [MUTEXES-1:0][MUTEX_W-1:0] seq;
    logic                            placed;
    int                              depth;
    int                              kind;
    int                              off;
    int                              c;

    graph_plan = '0;

    // directed: unlock of a mutex never held, locks from empty stacks,
    // lock chains on the lowest and highest threads, unlock from the middle
    // and the bottom of a stack
    queue_event(CMD_UNLOCK, 2'd0, 3'd0);
    queue_event(CMD_LOCK,   2'd0, 3'd0);
    queue_event(CMD_LOCK,   2'd0, 3'd3);
    queue_event(CMD_LOCK,   2'd0, 3'd7);
    queue_event(CMD_LOCK,   2'd3, 3'd1);
    queue_event(CMD_LOCK,   2'd3, 3'd2);
    queue_event(CMD_LOCK,   2'd1, 3'd0);
    queue_event(CMD_LOCK,   2'd1, 3'd3);
    queue_event(CMD_LOCK,   2'd1, 3'd5);
    queue_event(CMD_UNLOCK, 2'd0, 3'd3);
    queue_event(CMD_LOCK,   2'd2, 3'd6);
    queue_event(CMD_LOCK,   2'd0, 3'd6);
    queue_event(CMD_UNLOCK, 2'd3, 3'd1);
    queue_event(CMD_UNLOCK, 2'd3, 3'd2);
    queue_event(CMD_UNLOCK, 2'd1, 3'd4);
    queue_event(CMD_LOCK,   2'd3, 3'd4);
    queue_event(CMD_UNLOCK, 2'd2, 3'd6);

    // random: locks that keep the graph acyclic, unlocks of held and unheld mutexes
    for (int i = 0; i < 480; i++) begin
      thr = THREAD_W'($urandom_range(0, THREADS - 1));
      depth = int'(graph_plan.depth[thr]);
      placed = 1'b0;
      if ($urandom_range(0, 99) < (depth < 4 ? 75 : 45)) begin
        for (int a = 0; a < 4 && !placed; a++) begin
          mtx = MUTEX_W'($urandom_range(0, MUTEXES - 1));
          if (!lock_closes_cycle(graph_plan, thr, mtx)) begin
            queue_event(CMD_LOCK, thr, mtx);
            placed = 1'b1;
          end
        end
      end
      if (!placed) begin
        if (depth > 0 && $urandom_range(0, 3) != 0)
          mtx = graph_plan.held[thr][$urandom_range(0, depth - 1)];
        else
          mtx = MUTEX_W'($urandom_range(0, MUTEXES - 1));
        queue_event(CMD_UNLOCK, thr, mtx);
      end
    end

    // closing deadlock: cross-stack cycle, full stack, or retaking the top mutex
    kind = $urandom_range(0, 2);
    placed = 1'b0;
    if (kind == 0) begin
      off = $urandom_range(0, THREADS * MUTEXES - 1);
      for (int j = 0; j < THREADS * MUTEXES && !placed; j++) begin
        c = (off + j) % (THREADS * MUTEXES);
        thr = THREAD_W'(c / MUTEXES);
        mtx = MUTEX_W'(c % MUTEXES);
        depth = int'(graph_plan.depth[thr]);
        if (depth > 0 && graph_plan.held[thr][depth-1] != mtx &&
            lock_closes_cycle(graph_plan, thr, mtx)) begin
          queue_event(CMD_LOCK, thr, mtx);
          placed = 1'b1;
        end
      end
    end else if (kind == 1) begin
      // empty one stack, fill it in graph order, then push onto the full stack
      thr = THREAD_W'($urandom_range(0, THREADS - 1));
      while (graph_plan.depth[thr] != 0) queue_event(CMD_UNLOCK, thr, graph_plan.held[thr][0]);
      seq = topo_order(graph_plan.order);
      for (int j = 0; j < MUTEXES; j++) queue_event(CMD_LOCK, thr, seq[j]);
      queue_event(CMD_LOCK, thr, MUTEX_W'($urandom_range(0, MUTEXES - 1)));
      placed = 1'b1;
    end
    if (!placed) begin
      thr = THREAD_W'($urandom_range(0, THREADS - 1));
      if (graph_plan.depth[thr] == 0)
        queue_event(CMD_LOCK, thr, MUTEX_W'($urandom_range(0, MUTEXES - 1)));
      depth = int'(graph_plan.depth[thr]);
      queue_event(CMD_LOCK, thr, graph_plan.held[thr][depth-1]);
    end

    // halted afterwards whatever comes
    for (int i = 0; i < 12; i++)
      queue_event(CMD_W'($urandom_range(0, 1)), THREAD_W'($urandom_range(0, THREADS - 1)),
                  MUTEX_W'($urandom_range(0, MUTEXES - 1)));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
